FILE: rtl/core/bti_pkg.sv
// Shared constants, codes and helper functions of the bilinear table interpolator.
package bti_pkg;

  localparam int MAX_COLUMNS_DEF = 16;
  localparam int MAX_ROWS_DEF    = 16;
  localparam int QUEUE_DEPTH     = 4;
  localparam int FRAC_W          = 16;
  localparam int CFG_IDX_W       = 3;

  localparam logic [31:0] X_MIN_RST  = 32'h0000_0000;
  localparam logic [31:0] X_MAX_RST  = 32'h0001_0000;
  localparam logic [31:0] Y_MIN_RST  = 32'h0000_0000;
  localparam logic [31:0] Y_MAX_RST  = 32'h0001_0000;
  localparam logic [4:0]  X_SIZE_RST = 5'd16;
  localparam logic [4:0]  Y_SIZE_RST = 5'd16;

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_WRITE  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_MIN  = 3'd0,
    CFG_X_MAX  = 3'd1,
    CFG_Y_MIN  = 3'd2,
    CFG_Y_MAX  = 3'd3,
    CFG_X_SIZE = 3'd4,
    CFG_Y_SIZE = 3'd5
  } cfg_reg_t;

  // Bits needed for an integer index below a count of m.
  function automatic int idx_w(input int m);
    idx_w = (m > 1) ? $clog2(m) : 1;
  endfunction

  // A size of zero acts as one, a size above the limit acts as the limit.
  function automatic logic [8:0] clamp_size(input logic [4:0] size, input int maxv);
    logic [8:0] lim;
    lim = 9'(maxv);
    if (size == 5'd0) begin
      clamp_size = 9'd1;
    end else if ({4'd0, size} > lim) begin
      clamp_size = lim;
    end else begin
      clamp_size = {4'd0, size};
    end
  endfunction

endpackage

FILE: rtl/core/bti_front.sv
// Front part: accepts words, maps both coordinates onto table indices by a pipelined divider.
module bti_front import bti_pkg::*; #(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = MAX_ROWS_DEF,
  localparam int QWX = idx_w(MAX_COLUMNS) + FRAC_W,
  localparam int QWY = idx_w(MAX_ROWS) + FRAC_W
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            in_kind,
  input  logic [31:0]     in_x_coord,
  input  logic [31:0]     in_y_coord,
  input  logic [7:0]      in_entry_index,
  input  logic [31:0]     in_entry_value,
  input  logic [31:0]     x_min,
  input  logic [31:0]     x_max,
  input  logic [31:0]     y_min,
  input  logic [31:0]     y_max,
  input  logic [4:0]      x_size,
  input  logic [4:0]      y_size,
  output logic            f_valid,
  input  logic            f_ready,
  output logic            f_kind,
  output logic [QWX-1:0]  f_ix,
  output logic [QWY-1:0]  f_iy,
  output logic [7:0]      f_entry_index,
  output logic [31:0]     f_entry_value
);

  localparam int NWX = idx_w(MAX_COLUMNS);
  localparam int NWY = idx_w(MAX_ROWS);
  localparam int NW  = (NWX > NWY) ? NWX : NWY;
  localparam int QW  = NW + FRAC_W;
  localparam int PW  = 32 + NW;
  localparam int L   = QW + 2;

  logic                adv;
  logic [1:0][NW-1:0]  n;
  logic [1:0][31:0]    crd;
  logic [1:0][31:0]    amin;
  logic [1:0][31:0]    amax;
  logic [1:0]          pre_sat;
  logic [1:0][QW-1:0]  pre_satv;
  logic [1:0][31:0]    pre_un;
  logic [1:0][31:0]    pre_ud;
  logic [1:0][PW-1:0]  prod;

  logic                v_r      [L];
  logic                kind_r   [L];
  logic [7:0]          eidx_r   [L];
  logic [31:0]         eval_r   [L];

  logic [1:0]          f1_sat_r;
  logic [1:0][QW-1:0]  f1_satv_r;
  logic [1:0][31:0]    f1_un_r;
  logic [1:0][31:0]    f1_ud_r;

  logic [31:0]         drem_r  [2][QW+1];
  logic [QW-1:0]       dbits_r [2][QW+1];
  logic [QW-1:0]       dq_r    [2][QW+1];
  logic [31:0]         dud_r   [2][QW+1];
  logic                dsat_r  [2][QW+1];
  logic [QW-1:0]       dsatv_r [2][QW+1];

  logic [QW-1:0]       ix_full;
  logic [QW-1:0]       iy_full;

  assign n[0] = NW'(clamp_size(x_size, MAX_COLUMNS) - 9'd1);
  assign n[1] = NW'(clamp_size(y_size, MAX_ROWS) - 9'd1);
  assign crd[0]  = in_x_coord;
  assign crd[1]  = in_y_coord;
  assign amin[0] = x_min;
  assign amin[1] = y_min;
  assign amax[0] = x_max;
  assign amax[1] = y_max;

  assign adv      = !v_r[L-1] || f_ready;
  assign in_stall = !adv;

  always_comb begin
    logic              a_lt_b;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic [32:0]       dc;
    logic [32:0]       dr;
    logic [QW-1:0]     top;
    for (int ax = 0; ax < 2; ax++) begin
      a_lt_b = $signed(amin[ax]) < $signed(amax[ax]);
      lo     = a_lt_b ? $signed(amin[ax]) : $signed(amax[ax]);
      hi     = a_lt_b ? $signed(amax[ax]) : $signed(amin[ax]);
      top    = {n[ax], {FRAC_W{1'b0}}};
      dc     = {crd[ax][31], crd[ax]} - {amin[ax][31], amin[ax]};
      dr     = {amax[ax][31], amax[ax]} - {amin[ax][31], amin[ax]};
      pre_un[ax] = dc[32] ? 32'((~dc) + 33'd1) : dc[31:0];
      pre_ud[ax] = dr[32] ? 32'((~dr) + 33'd1) : dr[31:0];
      if ($signed(crd[ax]) < lo) begin
        pre_sat[ax]  = 1'b1;
        pre_satv[ax] = a_lt_b ? '0 : top;
      end else if ($signed(crd[ax]) > hi) begin
        pre_sat[ax]  = 1'b1;
        pre_satv[ax] = a_lt_b ? top : '0;
      end else if (amin[ax] == amax[ax]) begin
        pre_sat[ax]  = 1'b1;
        pre_satv[ax] = '0;
      end else begin
        pre_sat[ax]  = 1'b0;
        pre_satv[ax] = '0;
      end
    end
  end

  always_comb begin
    for (int ax = 0; ax < 2; ax++) begin
      prod[ax] = PW'(f1_un_r[ax]) * PW'(n[ax]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < L; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (adv) begin
      v_r[0] <= in_valid;
      for (int k = 1; k < L; k++) begin
        v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind_r[0] <= in_kind;
      eidx_r[0] <= in_entry_index;
      eval_r[0] <= in_entry_value;
      for (int k = 1; k < L; k++) begin
        kind_r[k] <= kind_r[k-1];
        eidx_r[k] <= eidx_r[k-1];
        eval_r[k] <= eval_r[k-1];
      end
      f1_sat_r  <= pre_sat;
      f1_satv_r <= pre_satv;
      f1_un_r   <= pre_un;
      f1_ud_r   <= pre_ud;
    end
  end

  for (genvar a = 0; a < 2; a++) begin : g_ax
    always_ff @(posedge clk) begin
      if (adv) begin
        drem_r[a][0]  <= prod[a][PW-1:NW];
        dbits_r[a][0] <= {prod[a][NW-1:0], {FRAC_W{1'b0}}};
        dq_r[a][0]    <= '0;
        dud_r[a][0]   <= f1_ud_r[a];
        dsat_r[a][0]  <= f1_sat_r[a];
        dsatv_r[a][0] <= f1_satv_r[a];
      end
    end

    for (genvar j = 1; j <= QW; j++) begin : g_div
      logic [32:0] t;
      logic [32:0] diff;
      logic        ge;

      assign t    = {drem_r[a][j-1], dbits_r[a][j-1][QW-1]};
      assign diff = t - {1'b0, dud_r[a][j-1]};
      assign ge   = t >= {1'b0, dud_r[a][j-1]};

      always_ff @(posedge clk) begin
        if (adv) begin
          drem_r[a][j]  <= ge ? diff[31:0] : t[31:0];
          dbits_r[a][j] <= {dbits_r[a][j-1][QW-2:0], 1'b0};
          dq_r[a][j]    <= {dq_r[a][j-1][QW-2:0], ge};
          dud_r[a][j]   <= dud_r[a][j-1];
          dsat_r[a][j]  <= dsat_r[a][j-1];
          dsatv_r[a][j] <= dsatv_r[a][j-1];
        end
      end
    end
  end

  assign ix_full = dsat_r[0][QW] ? dsatv_r[0][QW] : dq_r[0][QW];
  assign iy_full = dsat_r[1][QW] ? dsatv_r[1][QW] : dq_r[1][QW];

  assign f_valid       = v_r[L-1];
  assign f_kind        = kind_r[L-1];
  assign f_ix          = ix_full[QWX-1:0];
  assign f_iy          = iy_full[QWY-1:0];
  assign f_entry_index = eidx_r[L-1];
  assign f_entry_value = eval_r[L-1];

endmodule

FILE: rtl/core/bti_queue.sv
// Short first-in first-out queue of words between the front and back parts.
module bti_queue import bti_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  localparam int PTW = idx_w(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);

  logic [W-1:0]   slot_r [DEPTH];
  logic [PTW-1:0] wr_ptr_r;
  logic [PTW-1:0] wr_ptr_nxt;
  logic [PTW-1:0] rd_ptr_r;
  logic [PTW-1:0] rd_ptr_nxt;
  logic [CW-1:0]  count_r;
  logic [CW-1:0]  count_nxt;
  logic           push;
  logic           pop;

  assign push_ready = count_r != CW'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTW'(DEPTH - 1)) ? '0 : wr_ptr_r + PTW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTW'(DEPTH - 1)) ? '0 : rd_ptr_r + PTW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/core/bti_back.sv
// Back part: table memory, corner read sequencer and bilinear blend pipeline.
module bti_back import bti_pkg::*; #(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = MAX_ROWS_DEF,
  localparam int QWX = idx_w(MAX_COLUMNS) + FRAC_W,
  localparam int QWY = idx_w(MAX_ROWS) + FRAC_W
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_pop,
  input  logic            q_kind,
  input  logic [QWX-1:0]  q_ix,
  input  logic [QWY-1:0]  q_iy,
  input  logic [7:0]      q_entry_index,
  input  logic [31:0]     q_entry_value,
  input  logic [4:0]      x_size,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [31:0]     out_interp_value
);

  localparam int NWX   = idx_w(MAX_COLUMNS);
  localparam int NWY   = idx_w(MAX_ROWS);
  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = idx_w(DEPTH);

  logic [31:0]        mem [DEPTH];
  logic               adv;
  logic               lookup;
  logic               wr_go;
  logic               wr_ok;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;
  logic [31:0]        rd_addr_full;
  logic [8:0]         cols;
  logic [NWX-1:0]     c0;
  logic [NWX-1:0]     c1;
  logic [NWY-1:0]     r0;
  logic [NWY-1:0]     r1;
  logic [NWX-1:0]     col_sel;
  logic [NWY-1:0]     row_sel;

  logic [1:0]         phase_r;
  logic [31:0]        rd_r;
  logic [31:0]        z11_r;
  logic [31:0]        z21_r;
  logic [31:0]        z12_r;
  logic               cv_r;
  logic [15:0]        cfx_r;
  logic [15:0]        cfy_r;

  logic signed [32:0] dz1;
  logic signed [32:0] dz2;
  logic signed [49:0] s1_c;
  logic signed [49:0] s2_c;
  logic               b1_v_r;
  logic signed [49:0] s1_r;
  logic signed [49:0] s2_r;
  logic [15:0]        b1_fy_r;

  logic               b2_v_r;
  logic signed [49:0] d_r;
  logic signed [65:0] base_r;
  logic [15:0]        b2_fy_r;

  logic               b3_v_r;
  logic [40:0]        pl_r;
  logic signed [41:0] ph_r;
  logic signed [65:0] base3_r;
  logic signed [65:0] sum_c;

  logic               out_valid_r;
  logic [31:0]        out_data_r;

  assign adv    = !out_valid_r || !out_stall;
  assign lookup = q_valid && (q_kind == KIND_LOOKUP);
  assign wr_go  = adv && q_valid && (q_kind == KIND_WRITE);
  assign q_pop  = adv && q_valid && ((q_kind == KIND_WRITE) || (phase_r == 2'd3));

  assign cols    = clamp_size(x_size, MAX_COLUMNS);
  assign c0      = q_ix[QWX-1:FRAC_W];
  assign r0      = q_iy[QWY-1:FRAC_W];
  assign c1      = c0 + NWX'(q_ix[FRAC_W-1:0] != '0);
  assign r1      = r0 + NWY'(q_iy[FRAC_W-1:0] != '0);
  assign col_sel = phase_r[0] ? c1 : c0;
  assign row_sel = phase_r[1] ? r1 : r0;
  assign rd_addr_full = 32'(col_sel) + 32'(row_sel) * 32'(cols);
  assign rd_addr = rd_addr_full[AW-1:0];
  assign wr_ok   = 32'(q_entry_index) < 32'(DEPTH);
  assign wr_addr = AW'(32'(q_entry_index));

  always_ff @(posedge clk) begin
    if (wr_go && wr_ok) begin
      mem[wr_addr] <= q_entry_value;
    end
    if (adv && lookup) begin
      rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 2'd0;
      cv_r    <= 1'b0;
    end else if (adv) begin
      if (lookup) begin
        phase_r <= phase_r + 2'd1;
      end
      cv_r <= lookup && (phase_r == 2'd3);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (phase_r == 2'd1) begin
        z11_r <= rd_r;
      end
      if (phase_r == 2'd2) begin
        z21_r <= rd_r;
      end
      if (phase_r == 2'd3) begin
        z12_r <= rd_r;
        cfx_r <= q_ix[FRAC_W-1:0];
        cfy_r <= q_iy[FRAC_W-1:0];
      end
    end
  end

  // The fourth corner is still in the read register when the blend starts.
  assign dz1  = $signed({z21_r[31], z21_r}) - $signed({z11_r[31], z11_r});
  assign dz2  = $signed({rd_r[31], rd_r}) - $signed({z12_r[31], z12_r});
  assign s1_c = $signed({{2{z11_r[31]}}, z11_r, 16'd0}) + $signed({1'b0, cfx_r}) * dz1;
  assign s2_c = $signed({{2{z12_r[31]}}, z12_r, 16'd0}) + $signed({1'b0, cfx_r}) * dz2;

  assign sum_c = base3_r + 66'(pl_r) + (66'(ph_r) <<< 25);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r      <= 1'b0;
      b2_v_r      <= 1'b0;
      b3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      b1_v_r      <= cv_r;
      b2_v_r      <= b1_v_r;
      b3_v_r      <= b2_v_r;
      out_valid_r <= b3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r       <= s1_c;
      s2_r       <= s2_c;
      b1_fy_r    <= cfy_r;
      d_r        <= s2_r - s1_r;
      base_r     <= $signed({s1_r, 16'd0}) + 66'sd2147483648;
      b2_fy_r    <= b1_fy_r;
      pl_r       <= 41'(b2_fy_r) * 41'(d_r[24:0]);
      ph_r       <= $signed({1'b0, b2_fy_r}) * $signed(d_r[49:25]);
      base3_r    <= base_r;
      out_data_r <= sum_c[63:32];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_interp_value = out_data_r;

  a_phase_holds_head: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != 2'd0) |-> (q_valid && (q_kind == KIND_LOOKUP)))
    else $error("corner sequence running without a lookup at the queue head");

  a_collect_phase: assert property (@(posedge clk) disable iff (!rst_n)
    cv_r |-> (phase_r == 2'd0))
    else $error("blend collect overlaps a running corner sequence");

  a_last_read_collects: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && lookup && (phase_r == 2'd3)) |=> cv_r)
    else $error("last corner read did not start a blend");

endmodule

FILE: rtl/core/bilinear_table_interpolator_unit.sv
// Top level of the bilinear table interpolator: configuration registers, front, queue and back.
//
//  channel | ports                                             | direction
//  --------+---------------------------------------------------+----------
//  in      | in_valid, in_stall, in_kind, in_x_coord, ...      | word in
//  out     | out_valid, out_stall, out_interp_value            | word out
//  cfg     | cfg_we, cfg_index, cfg_data                       | write only
//
// The front takes one word a cycle while in_stall is low; its divider makes one quotient
// bit per stage. The back reads the four corners of a lookup word one after another
// from the table memory, and writes a table write word into it. After the last corner
// read, a lookup result passes the collect register and blend stages b1, b2 and b3 to
// the output register. Reset clears all control state; the table memory holds no defined
// value until written. A stalled output freezes the back, and the front runs on until the queue fills.
module bilinear_table_interpolator_unit import bti_pkg::*; #(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_kind,
  input  logic [31:0]          in_x_coord,
  input  logic [31:0]          in_y_coord,
  input  logic [7:0]           in_entry_index,
  input  logic [31:0]          in_entry_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [31:0]          out_interp_value,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int QWX = idx_w(MAX_COLUMNS) + FRAC_W;
  localparam int QWY = idx_w(MAX_ROWS) + FRAC_W;
  localparam int QDW = 1 + QWX + QWY + 8 + 32;

  logic [31:0]    x_min_r;
  logic [31:0]    x_max_r;
  logic [31:0]    y_min_r;
  logic [31:0]    y_max_r;
  logic [4:0]     x_size_r;
  logic [4:0]     y_size_r;

  logic           f_valid;
  logic           f_ready;
  logic           f_kind;
  logic [QWX-1:0] f_ix;
  logic [QWY-1:0] f_iy;
  logic [7:0]     f_entry_index;
  logic [31:0]    f_entry_value;

  logic           q_valid;
  logic           q_pop;
  logic [QDW-1:0] q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r  <= X_MIN_RST;
      x_max_r  <= X_MAX_RST;
      y_min_r  <= Y_MIN_RST;
      y_max_r  <= Y_MAX_RST;
      x_size_r <= X_SIZE_RST;
      y_size_r <= Y_SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_X_MIN: begin
          x_min_r <= cfg_data;
        end
        CFG_X_MAX: begin
          x_max_r <= cfg_data;
        end
        CFG_Y_MIN: begin
          y_min_r <= cfg_data;
        end
        CFG_Y_MAX: begin
          y_max_r <= cfg_data;
        end
        CFG_X_SIZE: begin
          x_size_r <= cfg_data[4:0];
        end
        CFG_Y_SIZE: begin
          y_size_r <= cfg_data[4:0];
        end
        default: begin
        end
      endcase
    end
  end

  bti_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_x_coord     (in_x_coord),
    .in_y_coord     (in_y_coord),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .x_min          (x_min_r),
    .x_max          (x_max_r),
    .y_min          (y_min_r),
    .y_max          (y_max_r),
    .x_size         (x_size_r),
    .y_size         (y_size_r),
    .f_valid        (f_valid),
    .f_ready        (f_ready),
    .f_kind         (f_kind),
    .f_ix           (f_ix),
    .f_iy           (f_iy),
    .f_entry_index  (f_entry_index),
    .f_entry_value  (f_entry_value)
  );

  bti_queue #(
    .W     (QDW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_kind, f_ix, f_iy, f_entry_index, f_entry_value}),
    .pop_valid  (q_valid),
    .pop_ready  (q_pop),
    .pop_data   (q_data)
  );

  bti_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .q_kind           (q_data[QDW-1]),
    .q_ix             (q_data[QDW-2 -: QWX]),
    .q_iy             (q_data[40 + QWY - 1 -: QWY]),
    .q_entry_index    (q_data[39:32]),
    .q_entry_value    (q_data[31:0]),
    .x_size           (x_size_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_interp_value (out_interp_value)
  );

endmodule

FILE: dv/tb_bilinear_table_interpolator_unit.sv
// Self-checking testbench of the bilinear table interpolator: filled map, directed and random lookups.
module tb_bilinear_table_interpolator_unit;
  import bti_pkg::*;

  localparam int QUIET_CYCLES = 80;
  localparam int STUCK_LIMIT  = 5000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_kind = KIND_LOOKUP;
  logic [31:0] in_x_coord = '0;
  logic [31:0] in_y_coord = '0;
  logic [7:0]  in_entry_index = '0;
  logic [31:0] in_entry_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_interp_value;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_X_MIN;
  logic [31:0] cfg_data = '0;

  logic [31:0] map_words [256];
  logic [31:0] x_lo_reg, x_hi_reg, y_lo_reg, y_hi_reg;
  logic [4:0]  x_cols_reg, y_rows_reg;
  logic [31:0] pending_interp [$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_left = 0;
  int          stuck_cycles = 0;

  bilinear_table_interpolator_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_x_coord(in_x_coord), .in_y_coord(in_y_coord),
    .in_entry_index(in_entry_index), .in_entry_value(in_entry_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_interp_value(out_interp_value),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int used_size(logic [4:0] s);
    if (s == 5'd0) return 1;
    if (s > 5'd16) return 16;
    return int'(s);
  endfunction

  // Index with 16 fractional bits for coordinate c on the span a..b over 0..n.
  function automatic longint unsigned scale_coord(longint c, longint a, longint b, int n);
    longint lo, hi;
    longint unsigned top, un, ud;
    top = longint'(n) << 16;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c < lo) return (a < b) ? 64'd0 : top;
    if (c > hi) return (a < b) ? top : 64'd0;
    if (a == b) return 64'd0;
    un = (c - a < 0) ? a - c : c - a;
    ud = (b - a < 0) ? a - b : b - a;
    return ((un * longint'(n)) << 16) / ud;
  endfunction

  function automatic logic [63:0] corner_word(int col, int row, int cols);
    logic [31:0] w;
    w = map_words[col + row * cols];
    return {{32{w[31]}}, w};
  endfunction

  function automatic logic [31:0] predict_interp(logic [31:0] xc, logic [31:0] yc);
    int cols, rows, c0, c1, r0, r1;
    longint unsigned ix, iy;
    logic [63:0] fx, fy, z11, z12, z21, z22, s1, s2, r;
    cols = used_size(x_cols_reg);
    rows = used_size(y_rows_reg);
    ix = scale_coord($signed(xc), $signed(x_lo_reg), $signed(x_hi_reg), cols - 1);
    iy = scale_coord($signed(yc), $signed(y_lo_reg), $signed(y_hi_reg), rows - 1);
    fx = ix & 64'hFFFF;
    fy = iy & 64'hFFFF;
    c0 = int'(ix >> 16);
    r0 = int'(iy >> 16);
    c1 = c0 + ((fx != 0) ? 1 : 0);
    r1 = r0 + ((fy != 0) ? 1 : 0);
    z11 = corner_word(c0, r0, cols);
    z12 = corner_word(c0, r1, cols);
    z21 = corner_word(c1, r0, cols);
    z22 = corner_word(c1, r1, cols);
    s1 = (z11 << 16) + fx * (z21 - z11);
    s2 = (z12 << 16) + fx * (z22 - z12);
    r = (s1 << 16) + fy * (s2 - s1);
    r = r + 64'h8000_0000;
    return r[63:32];
  endfunction

  // Sends one word and records its expected result once it is taken.
  task automatic send_word(logic kind, logic [31:0] xc, logic [31:0] yc,
                           logic [7:0] pos, logic [31:0] val);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_x_coord <= xc;
    in_y_coord <= yc;
    in_entry_index <= pos;
    in_entry_value <= val;
    do @(posedge clk); while (in_stall);
    if (kind == KIND_WRITE) begin
      map_words[pos] = val;
    end else begin
      pending_interp.push_back(predict_interp(xc, yc));
    end
  endtask

  task automatic lookup(logic [31:0] xc, logic [31:0] yc);
    send_word(KIND_LOOKUP, xc, yc, 8'($urandom), $urandom);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_interp.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(cfg_reg_t idx, logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_X_MIN:  x_lo_reg = v;
      CFG_X_MAX:  x_hi_reg = v;
      CFG_Y_MIN:  y_lo_reg = v;
      CFG_Y_MAX:  y_hi_reg = v;
      CFG_X_SIZE: x_cols_reg = v[4:0];
      CFG_Y_SIZE: y_rows_reg = v[4:0];
      default: ;
    endcase
  endtask

  task automatic set_map(logic [31:0] xa, logic [31:0] xb, logic [31:0] ya,
                         logic [31:0] yb, logic [4:0] xs, logic [4:0] ys);
    drain();
    set_reg(CFG_X_MIN, xa);
    set_reg(CFG_X_MAX, xb);
    set_reg(CFG_Y_MIN, ya);
    set_reg(CFG_Y_MAX, yb);
    set_reg(CFG_X_SIZE, {27'd0, xs});
    set_reg(CFG_Y_SIZE, {27'd0, ys});
  endtask

  // Mostly near the configured span, sometimes anywhere.
  function automatic logic [31:0] pick_coord(logic [31:0] a, logic [31:0] b);
    longint lo, hi;
    longint unsigned r;
    lo = ($signed(a) < $signed(b)) ? $signed(a) : $signed(b);
    hi = ($signed(a) < $signed(b)) ? $signed(b) : $signed(a);
    if ($urandom_range(9) == 0) return $urandom;
    r = {$urandom, $urandom};
    return 32'(lo - 2 + longint'(r % longint'(hi - lo + 5)));
  endfunction

  function automatic logic [31:0] pick_bound();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom;
      default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  task automatic test_fill_table();
    for (int i = 0; i < 256; i++) begin
      case (i)
        0: send_word(KIND_WRITE, $urandom, $urandom, 8'(i), 32'h7FFF_FFFF);
        1: send_word(KIND_WRITE, $urandom, $urandom, 8'(i), 32'h8000_0000);
        2: send_word(KIND_WRITE, $urandom, $urandom, 8'(i), 32'hFFFF_FFFF);
        3: send_word(KIND_WRITE, $urandom, $urandom, 8'(i), 32'h0000_0000);
        default: send_word(KIND_WRITE, $urandom, $urandom, 8'(i), $urandom);
      endcase
    end
  endtask

  task automatic test_directed_lookups();
    lookup(32'h0000_0000, 32'h0000_0000);
    lookup(32'h0001_0000, 32'h0001_0000);
    lookup(32'h8000_0000, 32'h7FFF_FFFF);
    lookup(32'h7FFF_FFFF, 32'h8000_0000);
    lookup(32'h0000_8000, 32'h0000_1111);
    lookup(32'h0000_1000, 32'h0000_0001);
    lookup(32'hFFFF_FFFF, 32'h0001_0001);
  endtask

  task automatic probe_span();
    lookup(x_lo_reg - 32'd1, y_lo_reg);
    lookup(x_lo_reg, y_hi_reg);
    lookup(x_hi_reg, y_hi_reg + 32'd1);
    lookup(x_hi_reg + 32'd1, y_lo_reg - 32'd1);
    lookup(pick_coord(x_lo_reg, x_hi_reg), pick_coord(y_lo_reg, y_hi_reg));
  endtask

  task automatic test_config_extremes();
    set_map(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 5'd1, 5'd16);
    probe_span();
    set_map(32'h0001_86A0, 32'h0001_86A0, 32'hFFFF_0000, 32'h0003_0000, 5'd31, 5'd0);
    probe_span();
    set_map(32'h0005_0000, 32'hFFFD_0000, 32'h0000_0400, 32'h0000_0000, 5'd5, 5'd7);
    probe_span();
  endtask

  task automatic test_random_phase(int idle, int stall, int count);
    set_map(pick_bound(), pick_bound(), pick_bound(), pick_bound(),
            ($urandom_range(7) == 0) ? 5'($urandom) : 5'($urandom_range(1, 16)),
            ($urandom_range(7) == 0) ? 5'($urandom) : 5'($urandom_range(1, 16)));
    send_idle_pct = idle;
    stall_pct = stall;
    repeat (count) begin
      if ($urandom_range(3) == 0) begin
        send_word(KIND_WRITE, $urandom, $urandom, 8'($urandom), $urandom);
      end else begin
        lookup(pick_coord(x_lo_reg, x_hi_reg), pick_coord(y_lo_reg, y_hi_reg));
      end
    end
  endtask

  task automatic test_output_hold_off();
    drain();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_left = 400;
    repeat (40) lookup(pick_coord(x_lo_reg, x_hi_reg), pick_coord(y_lo_reg, y_hi_reg));
  endtask

  always @(posedge clk) begin
    out_stall <= (hold_left > 0) || ($urandom_range(99) < stall_pct);
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_interp.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, out_interp_value);
        mismatches++;
      end else begin
        if (out_interp_value !== pending_interp[0]) begin
          $display("%0t: interp_value mismatch, expected %h, actual %h",
                   $time, pending_interp[0], out_interp_value);
          mismatches++;
        end
        void'(pending_interp.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles > STUCK_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    x_lo_reg = X_MIN_RST;
    x_hi_reg = X_MAX_RST;
    y_lo_reg = Y_MIN_RST;
    y_hi_reg = Y_MAX_RST;
    x_cols_reg = X_SIZE_RST;
    y_rows_reg = Y_SIZE_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fill_table();
    test_directed_lookups();
    test_config_extremes();
    test_random_phase(0, 0, 35);
    test_random_phase(49, 0, 35);
    test_random_phase(0, 49, 35);
    test_random_phase(37, 37, 35);
    test_output_hold_off();
    drain();
    if (mismatches == 0 && pending_interp.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: bilinear_table_interpolator_unit.f
rtl/core/bti_pkg.sv
rtl/core/bti_front.sv
rtl/core/bti_queue.sv
rtl/core/bti_back.sv
rtl/core/bilinear_table_interpolator_unit.sv
dv/tb_bilinear_table_interpolator_unit.sv
